### src/lbmp_pkg.sv
// shared types and constants for the laser beam to map point unit
`timescale 1ns / 1ps
package lbmp_pkg;

   // cordic datapath widths
   localparam int TRIG_W  = 34;
   localparam int ARC_LEN = 24;
   localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;

   // arc tangent of 2^-i in 32-bit turn units
   localparam logic [31:0] ARC_TABLE [0:ARC_LEN-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   // register indexes of the control port
   typedef enum logic [2:0] {
      CSR_ANGLE_START = 3'd0,
      CSR_ANGLE_STEP  = 3'd1,
      CSR_RANGE_MIN   = 3'd2,
      CSR_RANGE_MAX   = 3'd3,
      CSR_PPM         = 3'd4,
      CSR_ORIGIN_COL  = 3'd5,
      CSR_ORIGIN_ROW  = 3'd6
   } csr_index_type;

   // settings seen by the front end
   typedef struct packed {
      logic [15:0] angle_start;
      logic [15:0] angle_step;
      logic [15:0] range_min;
      logic [15:0] range_max;
   } front_cfg_type;

   // settings seen by the back end
   typedef struct packed {
      logic [7:0] ppm;
      logic [9:0] origin_col;
      logic [9:0] origin_row;
   } back_cfg_type;

   // per-beam data carried beside the rotation
   typedef struct packed {
      logic               hit;
      logic [15:0]        range;
      logic signed [23:0] pose_x;
      logic signed [23:0] pose_y;
   } tag_type;

   // classified beam waiting in the queue
   typedef struct packed {
      tag_type     tag;
      logic [15:0] angle;
   } job_type;

endpackage

### src/lbmp_front.sv
// front end: classifies a beam and forms its absolute angle
`timescale 1ns / 1ps
module lbmp_front #(
   parameter int MAX_BEAMS = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [10:0]           beam_index,
   input  logic [15:0]           beam_range,
   input  logic signed [23:0]    pose_x,
   input  logic signed [23:0]    pose_y,
   input  logic [15:0]           pose_heading,
   input  logic                  pose_known,
   input  lbmp_pkg::front_cfg_type cfg,
   output logic                  job_valid,
   output lbmp_pkg::job_type     job
);
   import lbmp_pkg::*;

   logic        valid_ff, valid_in;
   job_type     job_ff, job_in;
   logic [26:0] step_prod;
   logic        idx_ok;

   // beam angle and hit test
   always_comb begin
      step_prod          = 27'(beam_index) * 27'(cfg.angle_step);
      idx_ok             = 32'(beam_index) < 32'(MAX_BEAMS);
      job_in.angle       = cfg.angle_start + step_prod[15:0] + pose_heading;
      job_in.tag.hit     = pose_known && idx_ok && (beam_range > cfg.range_min)
                           && (beam_range < cfg.range_max);
      job_in.tag.range   = beam_range;
      job_in.tag.pose_x  = pose_x;
      job_in.tag.pose_y  = pose_y;
      valid_in           = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;
endmodule

### src/lbmp_fifo.sv
// two-entry queue between the front end and the rotation pipeline
`timescale 1ns / 1ps
module lbmp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lbmp_pkg::job_type push_job,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output lbmp_pkg::job_type head_job
);
   import lbmp_pkg::*;

   job_type     entry_ff [0:1];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   // pointer and count update
   always_comb begin
      do_push   = push && (count_ff != 2'd2);
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign not_empty = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign head_job  = entry_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   // the rotation pipeline pops whenever the queue holds a beat, so the queue never overflows
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue overflow");
   // a lone beat in the queue, with no push beside it, is gone by the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) && !push |=> count_ff == 2'd0)
      else $error("queue did not drain");
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
`endif
endmodule

### src/lbmp_cordic.sv
// pipelined rotation cordic giving sine and cosine, one stage per iteration
`timescale 1ns / 1ps
module lbmp_cordic #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  lbmp_pkg::job_type             in_job,
   output logic                          out_valid,
   output lbmp_pkg::tag_type             out_tag,
   output logic                          out_flip,
   output logic signed [lbmp_pkg::TRIG_W-1:0] out_cos,
   output logic signed [lbmp_pkg::TRIG_W-1:0] out_sin
);
   import lbmp_pkg::*;

   localparam int N = (CORDIC_STAGES > ARC_LEN) ? ARC_LEN : CORDIC_STAGES;

   logic signed [TRIG_W-1:0] x_ff [0:N];
   logic signed [TRIG_W-1:0] y_ff [0:N];
   logic signed [TRIG_W-1:0] z_ff [0:N];
   logic signed [TRIG_W-1:0] x_in [0:N];
   logic signed [TRIG_W-1:0] y_in [0:N];
   logic signed [TRIG_W-1:0] z_in [0:N];
   logic                     valid_ff [0:N];
   logic                     flip_ff  [0:N];
   tag_type                  tag_ff   [0:N];
   logic [31:0]              turn;
   logic                     flip_in;

   // fold the second and third quadrants by a half turn
   always_comb begin
      flip_in = in_job.angle[15] ^ in_job.angle[14];
      turn    = {in_job.angle ^ {flip_in, 15'b0}, 16'b0};
      x_in[0] = GAIN_Q30;
      y_in[0] = '0;
      z_in[0] = TRIG_W'($signed(turn));
   end

   // one micro-rotation per stage
   for (genvar g = 0; g < N; g++) begin : g_stage
      logic signed [TRIG_W-1:0] dx, dy, arc;
      always_comb begin
         dx  = y_ff[g] >>> g;
         dy  = x_ff[g] >>> g;
         arc = $signed({2'b00, ARC_TABLE[g]});
         if (!z_ff[g][TRIG_W-1]) begin
            x_in[g+1] = x_ff[g] - dx;
            y_in[g+1] = y_ff[g] + dy;
            z_in[g+1] = z_ff[g] - arc;
         end else begin
            x_in[g+1] = x_ff[g] + dx;
            y_in[g+1] = y_ff[g] - dy;
            z_in[g+1] = z_ff[g] + arc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= N; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= N; i++) valid_ff[i] <= valid_ff[i-1];
      end
      x_ff[0]    <= x_in[0];
      y_ff[0]    <= y_in[0];
      z_ff[0]    <= z_in[0];
      flip_ff[0] <= flip_in;
      tag_ff[0]  <= in_job.tag;
      for (int i = 1; i <= N; i++) begin
         x_ff[i]    <= x_in[i];
         y_ff[i]    <= y_in[i];
         z_ff[i]    <= z_in[i];
         flip_ff[i] <= flip_ff[i-1];
         tag_ff[i]  <= tag_ff[i-1];
      end
   end

   assign out_valid = valid_ff[N];
   assign out_tag   = tag_ff[N];
   assign out_flip  = flip_ff[N];
   assign out_cos   = x_ff[N];
   assign out_sin   = y_ff[N];
endmodule

### src/lbmp_back.sv
// back end: scales by range, adds the pose and maps to pixels
`timescale 1ns / 1ps
module lbmp_back #(
   parameter int MAP_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lbmp_pkg::back_cfg_type        cfg,
   input  logic                          in_valid,
   input  lbmp_pkg::tag_type             in_tag,
   input  logic                          in_flip,
   input  logic signed [lbmp_pkg::TRIG_W-1:0] in_cos,
   input  logic signed [lbmp_pkg::TRIG_W-1:0] in_sin,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic signed [23:0]            rsp_world_a,
   output logic signed [23:0]            rsp_world_b,
   output logic [9:0]                    rsp_pixel_col,
   output logic [9:0]                    rsp_pixel_row,
   output logic                          rsp_in_map
);
   import lbmp_pkg::*;

   localparam logic signed [22:0] MAP_LAST = 23'(MAP_SIZE - 1);

   // stage a: range products
   logic                     va_ff;
   tag_type                  ta_ff;
   logic signed [50:0]       pa_ff, pa_in, pb_ff, pb_in;
   logic signed [TRIG_W-1:0] sin_fix, cos_fix;
   logic signed [16:0]       rng_s;

   always_comb begin
      sin_fix = in_flip ? -in_sin : in_sin;
      cos_fix = in_flip ? -in_cos : in_cos;
      rng_s   = $signed({1'b0, in_tag.range});
      pa_in   = rng_s * sin_fix;
      pb_in   = rng_s * cos_fix;
   end

   // stage b: round, add pose, saturate
   logic                va_b_ff;
   logic                hb_ff;
   logic signed [23:0]  wa_ff, wa_in, wb_ff, wb_in;
   logic signed [50:0]  ra, rb;
   logic signed [25:0]  sa, sb;

   always_comb begin
      ra = pa_ff + (51'sd1 <<< 29);
      rb = pb_ff + (51'sd1 <<< 29);
      sa = {{5{ra[50]}}, ra[50:30]} + {{2{ta_ff.pose_y[23]}}, ta_ff.pose_y};
      sb = {{5{rb[50]}}, rb[50:30]} + {{2{ta_ff.pose_x[23]}}, ta_ff.pose_x};
      if (sa > 26'sd8388607)       wa_in = 24'sh7FFFFF;
      else if (sa < -26'sd8388608) wa_in = 24'sh800000;
      else                         wa_in = sa[23:0];
      if (sb > 26'sd8388607)       wb_in = 24'sh7FFFFF;
      else if (sb < -26'sd8388608) wb_in = 24'sh800000;
      else                         wb_in = sb[23:0];
   end

   // stage c: scale to pixels
   logic                vc_ff, hc_ff;
   logic signed [23:0]  wac_ff, wbc_ff;
   logic signed [32:0]  qa_ff, qa_in, qb_ff, qb_in;
   logic signed [8:0]   ppm_s;

   always_comb begin
      ppm_s = $signed({1'b0, cfg.ppm});
      qa_in = ppm_s * wa_ff;
      qb_in = ppm_s * wb_ff;
   end

   // stage d: round, add origin, clamp
   logic signed [32:0] ra2, rb2;
   logic signed [22:0] pc, pr;
   logic [9:0]         col_in, row_in;
   logic               in_map_in;

   always_comb begin
      ra2       = qa_ff + 33'sd2048;
      rb2       = qb_ff + 33'sd2048;
      pc        = {{2{ra2[32]}}, ra2[32:12]} + $signed({13'b0, cfg.origin_col});
      pr        = {{2{rb2[32]}}, rb2[32:12]} + $signed({13'b0, cfg.origin_row});
      in_map_in = 1'b1;
      if (pc < 23'sd0) begin
         col_in = '0;
         in_map_in = 1'b0;
      end else if (pc > MAP_LAST) begin
         col_in = MAP_LAST[9:0];
         in_map_in = 1'b0;
      end else begin
         col_in = pc[9:0];
      end
      if (pr < 23'sd0) begin
         row_in = '0;
         in_map_in = 1'b0;
      end else if (pr > MAP_LAST) begin
         row_in = MAP_LAST[9:0];
         in_map_in = 1'b0;
      end else begin
         row_in = pr[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff     <= 1'b0;
         va_b_ff   <= 1'b0;
         vc_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         va_ff     <= in_valid;
         va_b_ff   <= va_ff;
         vc_ff     <= va_b_ff;
         rsp_valid <= vc_ff;
      end
      ta_ff  <= in_tag;
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      hb_ff  <= ta_ff.hit;
      wa_ff  <= wa_in;
      wb_ff  <= wb_in;
      hc_ff  <= hb_ff;
      wac_ff <= wa_ff;
      wbc_ff <= wb_ff;
      qa_ff  <= qa_in;
      qb_ff  <= qb_in;
      // a miss reports zero in every field
      rsp_hit       <= hc_ff;
      rsp_world_a   <= hc_ff ? wac_ff : '0;
      rsp_world_b   <= hc_ff ? wbc_ff : '0;
      rsp_pixel_col <= hc_ff ? col_in : '0;
      rsp_pixel_row <= hc_ff ? row_in : '0;
      rsp_in_map    <= hc_ff & in_map_in;
   end
endmodule

### src/laser_beam_to_map_point_unit.sv
// top level of the laser beam to map point unit
`timescale 1ns / 1ps
// Projects laser beams onto the world plane and a square raster map. One beam
// is taken per clock cycle without gaps (busy stays low in normal use, it only
// reflects a full hand-off queue), and each beam gives exactly one result beat,
// shown for a single cycle with rsp_valid, in input order. A beam passes from
// start through the front-end register, the hand-off queue, the rotation
// pipeline (stages capped at 24) and back-end stages a to d. Control registers
// are written through csr_we; write them only while no beam is in flight.
module laser_beam_to_map_point_unit #(
   parameter int MAP_SIZE      = 1024,
   parameter int MAX_BEAMS     = 2048,
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [10:0]        req_beam_index,
   input  logic [15:0]        req_beam_range,
   input  logic signed [23:0] req_pose_x,
   input  logic signed [23:0] req_pose_y,
   input  logic [15:0]        req_pose_heading,
   input  logic               req_pose_known,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic signed [23:0] rsp_world_a,
   output logic signed [23:0] rsp_world_b,
   output logic [9:0]         rsp_pixel_col,
   output logic [9:0]         rsp_pixel_row,
   output logic               rsp_in_map,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import lbmp_pkg::*;

   front_cfg_type fcfg_ff;
   back_cfg_type  bcfg_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fcfg_ff.angle_start <= 16'd0;
         fcfg_ff.angle_step  <= 16'd0;
         fcfg_ff.range_min   <= 16'd78;
         fcfg_ff.range_max   <= 16'd16384;
         bcfg_ff.ppm         <= 8'd60;
         bcfg_ff.origin_col  <= 10'd200;
         bcfg_ff.origin_row  <= 10'd200;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ANGLE_START: fcfg_ff.angle_start <= csr_wdata;
            CSR_ANGLE_STEP:  fcfg_ff.angle_step  <= csr_wdata;
            CSR_RANGE_MIN:   fcfg_ff.range_min   <= csr_wdata;
            CSR_RANGE_MAX:   fcfg_ff.range_max   <= csr_wdata;
            CSR_PPM:         bcfg_ff.ppm         <= csr_wdata[7:0];
            CSR_ORIGIN_COL:  bcfg_ff.origin_col  <= csr_wdata[9:0];
            CSR_ORIGIN_ROW:  bcfg_ff.origin_row  <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   logic     job_valid, q_not_empty, q_full;
   job_type  job, head_job;
   logic     c_valid, c_flip;
   tag_type  c_tag;
   logic signed [TRIG_W-1:0] c_cos, c_sin;

   assign busy = q_full;

   // front end
   lbmp_front #(.MAX_BEAMS(MAX_BEAMS)) u_front (
      .clock, .reset,
      .in_valid(start && !busy),
      .beam_index(req_beam_index), .beam_range(req_beam_range),
      .pose_x(req_pose_x), .pose_y(req_pose_y),
      .pose_heading(req_pose_heading), .pose_known(req_pose_known),
      .cfg(fcfg_ff), .job_valid, .job
   );

   // hand-off queue
   lbmp_fifo u_fifo (
      .clock, .reset,
      .push(job_valid), .push_job(job),
      .pop(q_not_empty), .not_empty(q_not_empty), .full(q_full),
      .head_job
   );

   // rotation pipeline
   lbmp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
      .clock, .reset,
      .in_valid(q_not_empty), .in_job(head_job),
      .out_valid(c_valid), .out_tag(c_tag), .out_flip(c_flip),
      .out_cos(c_cos), .out_sin(c_sin)
   );

   // back end
   lbmp_back #(.MAP_SIZE(MAP_SIZE)) u_back (
      .clock, .reset, .cfg(bcfg_ff),
      .in_valid(c_valid), .in_tag(c_tag), .in_flip(c_flip),
      .in_cos(c_cos), .in_sin(c_sin),
      .rsp_valid, .rsp_hit, .rsp_world_a, .rsp_world_b,
      .rsp_pixel_col, .rsp_pixel_row, .rsp_in_map
   );

`ifndef NO_ASSERTIONS
   // a missed beam reports all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_world_a == 24'sd0 && rsp_world_b == 24'sd0
      && rsp_pixel_col == 10'd0 && rsp_pixel_row == 10'd0)
      else $error("miss beat carries data");
   // in-map flag only on hits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_map |-> rsp_hit)
      else $error("in_map without hit");
   // the pipeline never pushes back
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
`endif
endmodule
